// ----- rtl/core/u8n1_pkg.sv -----
// Shared types and constants for the 8N1 UART transceiver.
// Used by the transmit unit, the receive unit and the top level.
package u8n1_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned STAGE_W  = 4;

    localparam logic [PERIOD_W-1:0] TX_PERIOD_RESET = 16'd100;
    localparam logic [PERIOD_W-1:0] RX_PERIOD_RESET = 16'd108;

    localparam logic [STAGE_W-1:0] TX_IDLE_STAGE  = 4'd0;
    localparam logic [STAGE_W-1:0] TX_START_STAGE = 4'd1;
    localparam logic [STAGE_W-1:0] TX_LAST_DATA   = 4'd9;
    localparam logic [STAGE_W-1:0] TX_STOP_STAGE  = 4'd10;
    localparam logic [STAGE_W-1:0] RX_START_STAGE = 4'd0;
    localparam logic [STAGE_W-1:0] RX_IDLE_STAGE  = 4'd9;

    localparam logic REG_TX_PERIOD = 1'b0;
    localparam logic REG_RX_PERIOD = 1'b1;

    typedef struct packed {
        logic tx_line;
        logic tx_busy;
        logic send_taken;
    } tx_result_t;

    typedef struct packed {
        logic       rx_valid;
        logic [7:0] rx_byte;
    } rx_result_t;

    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
        eff_period = (p == '0) ? PERIOD_W'(1) : p;
    endfunction

endpackage

// ----- rtl/core/uart_8n1_transceiver_top.sv -----
// Top level of the 8N1 UART transceiver: stream ports, configuration registers.
// Depends on u8n1_pkg, u8n1_tx and u8n1_rx.
//
// Each word on the slave stream is one timing tick: the sampled receive level and
// an optional byte to send. Each accepted word yields exactly one result word on
// the master stream with the transmit level and busy flag after the tick, whether
// the send request was taken, and a received byte when one completes.
// An accepted word enters an input register; when the output register is empty or
// being taken, the transmit and receive units advance one tick and the result is
// captured in the output register, where it is offered on the master stream.
// Throughput is one word per cycle while m_tready keeps the output flowing;
// s_tready stays high while the output register drains or is empty.
// When m_tready is low, one result waits in the output register and one word
// waits in the input register; s_tready then drops until the result is taken.
// Reset clears both stream stages, idles the transmitter with the line high,
// idles the receiver, and loads bit periods of 100 (transmit) and 108 (receive)
// ticks. Bit periods are written through cfg_we/cfg_addr/cfg_data; the user must
// write them only while idle, which the block does not enforce; a period of zero acts as one.
module uart_8n1_transceiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_line, send_request, send_value[7:0], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // tx_line, tx_busy, send_taken, rx_valid, rx_byte[7:0], zero fill
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data
);

    logic [u8n1_pkg::PERIOD_W-1:0] tx_period_reg;
    logic [u8n1_pkg::PERIOD_W-1:0] rx_period_reg;
    logic                          in_valid_reg;
    logic [9:0]                    in_data_reg;
    logic                          out_valid_reg;
    logic [11:0]                   out_data_reg;
    logic                          step;
    u8n1_pkg::tx_result_t          tx_res;
    u8n1_pkg::rx_result_t          rx_res;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_period_reg <= u8n1_pkg::TX_PERIOD_RESET;
            rx_period_reg <= u8n1_pkg::RX_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                u8n1_pkg::REG_TX_PERIOD: tx_period_reg <= cfg_data;
                u8n1_pkg::REG_RX_PERIOD: rx_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata[9:0];
        end
        if (step)
        begin
            out_data_reg <= {rx_res.rx_byte, rx_res.rx_valid, tx_res.send_taken,
                             tx_res.tx_busy, tx_res.tx_line};
        end
    end

    u8n1_tx u_tx (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .send_request (in_data_reg[1]),
        .send_value   (in_data_reg[9:2]),
        .bit_period   (tx_period_reg),
        .result       (tx_res)
    );

    u8n1_rx u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_line    (in_data_reg[0]),
        .bit_period (rx_period_reg),
        .result     (rx_res)
    );

endmodule

// ----- rtl/core/u8n1_tx.sv -----
// Transmit unit of the 8N1 UART: start bit, eight data bits LSB first, stop bit.
// Depends on u8n1_pkg.
module u8n1_tx (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          send_request,
    input  logic [7:0]                    send_value,
    input  logic [u8n1_pkg::PERIOD_W-1:0] bit_period,
    output u8n1_pkg::tx_result_t          result
);

    logic [u8n1_pkg::STAGE_W-1:0]  stage_reg, stage_next;
    logic [u8n1_pkg::PERIOD_W-1:0] count_reg, count_next, count_inc;
    logic [7:0]                    shift_reg, shift_next;
    logic                          level_reg, level_next;
    logic                          taken;

    always_comb
    begin
        stage_next = stage_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        level_next = level_reg;
        taken      = 1'b0;
        count_inc  = count_reg + u8n1_pkg::PERIOD_W'(1);
        if (stage_reg == u8n1_pkg::TX_IDLE_STAGE)
        begin
            if (send_request)
            begin
                taken      = 1'b1;
                stage_next = u8n1_pkg::TX_START_STAGE;
                count_next = '0;
                shift_next = send_value;
                level_next = 1'b0;
            end
        end
        else
        begin
            count_next = count_inc;
            if (count_inc >= u8n1_pkg::eff_period(bit_period))
            begin
                count_next = '0;
                if (stage_reg >= u8n1_pkg::TX_STOP_STAGE)
                begin
                    stage_next = u8n1_pkg::TX_IDLE_STAGE;
                    level_next = 1'b1;
                end
                else if (stage_reg == u8n1_pkg::TX_LAST_DATA)
                begin
                    stage_next = u8n1_pkg::TX_STOP_STAGE;
                    level_next = 1'b1;
                end
                else
                begin
                    stage_next = stage_reg + u8n1_pkg::STAGE_W'(1);
                    level_next = shift_reg[0];
                    shift_next = {1'b0, shift_reg[7:1]};
                end
            end
        end
    end

    assign result.tx_line    = level_next;
    assign result.tx_busy    = (stage_next != u8n1_pkg::TX_IDLE_STAGE);
    assign result.send_taken = taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= u8n1_pkg::TX_IDLE_STAGE;
            count_reg <= '0;
            shift_reg <= '0;
            level_reg <= 1'b1;
        end
        else if (step)
        begin
            stage_reg <= stage_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            level_reg <= level_next;
        end
    end

endmodule

// ----- rtl/core/u8n1_rx.sv -----
// Receive unit of the 8N1 UART: start on a falling edge, sample eight bits LSB first.
// Depends on u8n1_pkg.
module u8n1_rx (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          rx_line,
    input  logic [u8n1_pkg::PERIOD_W-1:0] bit_period,
    output u8n1_pkg::rx_result_t          result
);

    logic [u8n1_pkg::STAGE_W-1:0]  stage_reg, stage_next, stage_inc;
    logic [u8n1_pkg::PERIOD_W-1:0] count_reg, count_next, count_inc;
    logic [7:0]                    shift_reg, shift_next;
    logic                          prev_reg;

    always_comb
    begin
        stage_next      = stage_reg;
        count_next      = count_reg;
        shift_next      = shift_reg;
        result.rx_valid = 1'b0;
        result.rx_byte  = '0;
        count_inc       = count_reg + u8n1_pkg::PERIOD_W'(1);
        stage_inc       = stage_reg + u8n1_pkg::STAGE_W'(1);
        if (stage_reg >= u8n1_pkg::RX_IDLE_STAGE)
        begin
            if (prev_reg && !rx_line)
            begin
                stage_next = u8n1_pkg::RX_START_STAGE;
                count_next = '0;
            end
        end
        else
        begin
            count_next = count_inc;
            if (count_inc >= u8n1_pkg::eff_period(bit_period))
            begin
                count_next = '0;
                stage_next = stage_inc;
                if (stage_inc == u8n1_pkg::RX_IDLE_STAGE)
                begin
                    result.rx_valid = 1'b1;
                    result.rx_byte  = shift_reg;
                end
                else
                begin
                    shift_next[stage_reg[2:0]] = rx_line;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= u8n1_pkg::RX_IDLE_STAGE;
            count_reg <= '0;
            shift_reg <= '0;
            prev_reg  <= 1'b1;
        end
        else if (step)
        begin
            stage_reg <= stage_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            prev_reg  <= rx_line;
        end
    end

endmodule
